// ===== src/tapc_pkg.sv =====
// ----------------------------------------------------------------------------
// tapc_pkg: shared types and constants for the tilt actuator controller
// Codes, field widths and the command/status structs between the controller
// and the tilt mapping datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package tapc_pkg;

  localparam int ADC_W  = 12;
  localparam int TILT_W = 16;
  localparam int TOL_W  = 10;
  localparam int MS_W   = 16;
  localparam int TIME_W = 32;
  localparam int SPAN_W = 12;

  localparam logic [ADC_W:0] MOTION_STEP    = 13'd3;
  localparam logic [7:0]     SERVED_ANTENNA = 8'd1;

  typedef logic [2:0] status_t;
  localparam status_t ST_IDLE   = 3'd0;
  localparam status_t ST_RUN    = 3'd1;
  localparam status_t ST_OK     = 3'd2;
  localparam status_t ST_HWERR  = 3'd3;
  localparam status_t ST_ACTJAM = 3'd4;
  localparam status_t ST_MOTJAM = 3'd5;

  localparam logic [1:0] OPC_START = 2'd0;
  localparam logic [1:0] OPC_POLL  = 2'd1;
  localparam logic [1:0] OPC_STOP  = 2'd2;

  localparam logic [1:0] OPER_MOVE = 2'd0;
  localparam logic [1:0] OPER_CAL  = 2'd1;
  localparam logic [1:0] OPER_TEST = 2'd2;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_BACK = 2'd3;

  localparam logic signed [1:0] DRV_BRAKE = 2'sb00;
  localparam logic signed [1:0] DRV_UP    = 2'sb01;
  localparam logic signed [1:0] DRV_DN    = 2'sb11;

  localparam logic [3:0] REG_TILT_MIN = 4'd0;
  localparam logic [3:0] REG_TILT_MAX = 4'd1;
  localparam logic [3:0] REG_TOL      = 4'd2;
  localparam logic [3:0] REG_SETTLE   = 4'd3;
  localparam logic [3:0] REG_STALL    = 4'd4;
  localparam logic [3:0] REG_MIN_SPAN = 4'd5;
  localparam logic [3:0] REG_DEF_LOW  = 4'd6;
  localparam logic [3:0] REG_DEF_HIGH = 4'd7;

  // mapping request: raw sample, ADC endpoints and tilt limits
  typedef struct packed {
    logic                     start;
    logic [ADC_W-1:0]         raw;
    logic [ADC_W-1:0]         lo;
    logic [ADC_W-1:0]         hi;
    logic signed [TILT_W-1:0] tmin;
    logic signed [TILT_W-1:0] tmax;
  } map_cmd_t;

  typedef struct packed {
    logic                     done;
    logic signed [TILT_W-1:0] tilt;
  } map_stat_t;

  // magnitude of an 18-bit signed difference
  function automatic logic [17:0] abs18(input logic signed [17:0] v);
    abs18 = v[17] ? 18'(-v) : 18'(v);
  endfunction

endpackage
`default_nettype wire

// ===== src/tapc_map.sv =====
// ----------------------------------------------------------------------------
// tapc_map: tilt mapping datapath
// tilt = tmin + (raw-lo)*(tmax-tmin)/(hi-lo), truncated toward zero, clamped.
// A multiply step, a restoring divider one bit a cycle, and a fix-up step.
// ----------------------------------------------------------------------------
`default_nettype none
module tapc_map (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire tapc_pkg::map_cmd_t  cmd,
  output tapc_pkg::map_stat_t      stat
);
  import tapc_pkg::*;

  localparam int DIFF_W = ADC_W + 1;
  localparam int SPN_W  = TILT_W + 1;
  localparam int PROD_W = DIFF_W + SPN_W;
  localparam int CNT_W  = $clog2(PROD_W);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIX} mstate_t;

  mstate_t                   mst_r, mst_nxt;
  logic signed [DIFF_W-1:0]  diff_r, diff_nxt;
  logic signed [DIFF_W-1:0]  den_r, den_nxt;
  logic signed [SPN_W-1:0]   span_r, span_nxt;
  logic signed [TILT_W-1:0]  tmin_r, tmin_nxt;
  logic signed [TILT_W-1:0]  tmax_r, tmax_nxt;
  logic                      neg_r, neg_nxt;
  logic [PROD_W-1:0]         num_r, num_nxt;
  logic [ADC_W-1:0]          rem_r, rem_nxt;
  logic [ADC_W-1:0]          dmag_r, dmag_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [TILT_W-1:0]  tilt_r, tilt_nxt;
  logic                      done_r, done_nxt;

  always_comb begin
    logic signed [PROD_W-1:0] prod;
    logic [DIFF_W-1:0]        dabs;
    logic [ADC_W:0]           trial;
    logic signed [PROD_W:0]   quo;
    logic signed [PROD_W+1:0] sum;
    mst_nxt  = mst_r;
    diff_nxt = diff_r;
    den_nxt  = den_r;
    span_nxt = span_r;
    tmin_nxt = tmin_r;
    tmax_nxt = tmax_r;
    neg_nxt  = neg_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    cnt_nxt  = cnt_r;
    tilt_nxt = tilt_r;
    done_nxt = 1'b0;
    prod  = diff_r * span_r;
    dabs  = den_r[DIFF_W-1] ? DIFF_W'(-den_r) : DIFF_W'(den_r);
    trial = {rem_r, num_r[PROD_W-1]};
    quo   = neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});
    sum   = (PROD_W+2)'(tmin_r) + (PROD_W+2)'(quo);
    unique case (mst_r)
      M_IDLE: begin
        if (cmd.start) begin
          diff_nxt = $signed({1'b0, cmd.raw}) - $signed({1'b0, cmd.lo});
          den_nxt  = $signed({1'b0, cmd.hi}) - $signed({1'b0, cmd.lo});
          span_nxt = SPN_W'(cmd.tmax) - SPN_W'(cmd.tmin);
          tmin_nxt = cmd.tmin;
          tmax_nxt = cmd.tmax;
          mst_nxt  = M_MUL;
        end
      end
      // register the product and its sign; equal endpoints give tmin
      M_MUL: begin
        if (den_r == '0) begin
          tilt_nxt = tmin_r;
          done_nxt = 1'b1;
          mst_nxt  = M_IDLE;
        end else begin
          num_nxt  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
          neg_nxt  = prod[PROD_W-1] ^ den_r[DIFF_W-1];
          dmag_nxt = dabs[ADC_W-1:0];
          rem_nxt  = '0;
          cnt_nxt  = CNT_W'(PROD_W - 1);
          mst_nxt  = M_DIV;
        end
      end
      // restoring division, one quotient bit per cycle
      M_DIV: begin
        if (trial >= {1'b0, dmag_r}) begin
          rem_nxt = ADC_W'(trial - {1'b0, dmag_r});
          num_nxt = {num_r[PROD_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[ADC_W-1:0];
          num_nxt = {num_r[PROD_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          mst_nxt = M_FIX;
        end
      end
      // apply sign, offset and clamp
      M_FIX: begin
        if (sum < (PROD_W+2)'(tmin_r)) begin
          tilt_nxt = tmin_r;
        end else if (sum > (PROD_W+2)'(tmax_r)) begin
          tilt_nxt = tmax_r;
        end else begin
          tilt_nxt = sum[TILT_W-1:0];
        end
        done_nxt = 1'b1;
        mst_nxt  = M_IDLE;
      end
      default: mst_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mst_r  <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      mst_r  <= mst_nxt;
      done_r <= done_nxt;
    end
    diff_r <= diff_nxt;
    den_r  <= den_nxt;
    span_r <= span_nxt;
    tmin_r <= tmin_nxt;
    tmax_r <= tmax_nxt;
    neg_r  <= neg_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    cnt_r  <= cnt_nxt;
    tilt_r <= tilt_nxt;
  end

  assign stat.done = done_r;
  assign stat.tilt = tilt_r;

endmodule
`default_nettype wire

// ===== src/tapc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tapc_ctrl: controller state machine
// Holds configuration and operation state, sequences tilt mappings and
// decides drive direction and status; registers each result beat.
// ----------------------------------------------------------------------------
`default_nettype none
module tapc_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire [1:0]                 in_opcode,
  input  wire [1:0]                 in_operation,
  input  wire [7:0]                 in_antenna,
  input  wire signed [15:0]         in_target_tenths,
  input  wire [11:0]                in_adc_sample,
  input  wire                       in_adc_ok,
  input  wire                       in_driver_fault,
  input  wire                       in_limit_low,
  input  wire                       in_limit_high,
  input  wire [31:0]                in_now_ms,
  input  wire                       cfg_we,
  input  wire [3:0]                 cfg_index,
  input  wire [15:0]                cfg_wdata,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [2:0]                out_status,
  output logic                      out_accepted,
  output logic signed [15:0]        out_tilt_tenths,
  output logic                      out_position_valid,
  output logic signed [1:0]         out_drive_direction,
  output logic                      out_driver_awake,
  output tapc_pkg::map_cmd_t        map_cmd,
  input  wire tapc_pkg::map_stat_t  map_stat
);
  import tapc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DISP, S_MAP1, S_MAP2, S_EMIT} state_t;

  state_t st_r, st_nxt;

  // configuration
  logic signed [TILT_W-1:0] tmin_r, tmax_r;
  logic [TOL_W-1:0]         tol_r;
  logic [MS_W-1:0]          settle_r, stall_to_r;
  logic [SPAN_W-1:0]        min_span_r;
  logic [ADC_W-1:0]         def_lo_r, def_hi_r;

  // operation state
  status_t                  run_r, run_nxt;
  logic [1:0]               oper_r, oper_nxt;
  logic [1:0]               phase_r, phase_nxt;
  logic signed [TILT_W-1:0] goal_r, goal_nxt, ret_r, ret_nxt;
  logic [TIME_W-1:0]        start_r, start_nxt, motion_r, motion_nxt;
  logic [ADC_W-1:0]         prev_r, prev_nxt;
  logic signed [1:0]        drv_r, drv_nxt;
  logic                     awake_r, awake_nxt;
  logic [ADC_W-1:0]         cap_lo_r, cap_lo_nxt, cap_hi_r, cap_hi_nxt;
  logic                     cap_lo_v_r, cap_lo_v_nxt, cap_hi_v_r, cap_hi_v_nxt;

  // latched item
  logic [1:0]               op_r, item_oper_r;
  logic [7:0]               ant_r;
  logic signed [TILT_W-1:0] tgt_r;
  logic [ADC_W-1:0]         raw_r;
  logic                     aok_r, flt_r, ll_r, lh_r;
  logic [TIME_W-1:0]        now_r;

  // pending result
  logic                     res_acc_r, res_acc_nxt, res_pv_r, res_pv_nxt;
  logic                     res_hwant_r, res_hwant_nxt;
  logic signed [TILT_W-1:0] res_pos_r, res_pos_nxt;

  map_cmd_t                 mcmd_r, mcmd_nxt;

  // output register
  logic                     ov_r, ov_nxt;
  status_t                  o_st_r, o_st_nxt;
  logic                     o_acc_r, o_acc_nxt, o_pv_r, o_pv_nxt, o_aw_r, o_aw_nxt;
  logic signed [TILT_W-1:0] o_pos_r, o_pos_nxt;
  logic signed [1:0]        o_dir_r, o_dir_nxt;

  logic                     in_acc;
  logic [ADC_W-1:0]         lo_end, hi_end;

  assign in_stall = (st_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign lo_end   = cap_lo_v_r ? cap_lo_r : def_lo_r;
  assign hi_end   = cap_hi_v_r ? cap_hi_r : def_hi_r;

  always_comb begin
    logic signed [TILT_W-1:0] cur;
    logic                     moved, stall_hit, at_goal, at_ret, lim_hit, span_bad;
    logic [TIME_W-1:0]        mt;
    st_nxt       = st_r;
    run_nxt      = run_r;
    oper_nxt     = oper_r;
    phase_nxt    = phase_r;
    goal_nxt     = goal_r;
    ret_nxt      = ret_r;
    start_nxt    = start_r;
    motion_nxt   = motion_r;
    prev_nxt     = prev_r;
    drv_nxt      = drv_r;
    awake_nxt    = awake_r;
    cap_lo_nxt   = cap_lo_r;
    cap_lo_v_nxt = cap_lo_v_r;
    cap_hi_nxt   = cap_hi_r;
    cap_hi_v_nxt = cap_hi_v_r;
    res_acc_nxt  = res_acc_r;
    res_pv_nxt   = res_pv_r;
    res_hwant_nxt = res_hwant_r;
    res_pos_nxt  = res_pos_r;
    mcmd_nxt     = mcmd_r;
    mcmd_nxt.start = 1'b0;
    ov_nxt       = ov_r && out_stall;
    o_st_nxt     = o_st_r;
    o_acc_nxt    = o_acc_r;
    o_pv_nxt     = o_pv_r;
    o_aw_nxt     = o_aw_r;
    o_pos_nxt    = o_pos_r;
    o_dir_nxt    = o_dir_r;

    cur       = map_stat.tilt;
    moved     = abs18(18'(raw_r) - 18'(prev_r)) >= 18'(MOTION_STEP);
    mt        = moved ? now_r : motion_r;
    stall_hit = (now_r - mt) >= TIME_W'(stall_to_r);
    at_goal   = abs18(18'(cur) - 18'(goal_r)) <= 18'(tol_r);
    at_ret    = abs18(18'(cur) - 18'(ret_r)) <= 18'(tol_r);
    lim_hit   = (drv_r == DRV_DN && ll_r) || (drv_r == DRV_UP && lh_r);
    span_bad  = abs18(18'(raw_r) - 18'(lo_end)) < 18'(min_span_r);

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt = S_DISP;
        end
      end
      // decode the item; items without a mapping finish here
      S_DISP: begin
        res_acc_nxt   = 1'b1;
        res_pv_nxt    = 1'b0;
        res_hwant_nxt = 1'b0;
        res_pos_nxt   = '0;
        mcmd_nxt.raw  = raw_r;
        mcmd_nxt.lo   = lo_end;
        mcmd_nxt.hi   = hi_end;
        mcmd_nxt.tmin = tmin_r;
        mcmd_nxt.tmax = tmax_r;
        st_nxt        = S_EMIT;
        case (op_r)
          OPC_START: begin
            if (ant_r != SERVED_ANTENNA || run_r == ST_RUN || flt_r || !aok_r) begin
              res_acc_nxt = 1'b0;
            end else begin
              mcmd_nxt.start = 1'b1;
              st_nxt         = S_MAP1;
            end
          end
          OPC_POLL: begin
            if (ant_r != SERVED_ANTENNA) begin
              res_hwant_nxt = 1'b1;
            end else if (run_r != ST_RUN) begin
              res_hwant_nxt = 1'b0;
            end else if (flt_r || !aok_r) begin
              drv_nxt   = DRV_BRAKE;
              awake_nxt = 1'b1;
              run_nxt   = ST_HWERR;
            end else begin
              mcmd_nxt.start = 1'b1;
              st_nxt         = S_MAP1;
            end
          end
          OPC_STOP: begin
            drv_nxt   = DRV_BRAKE;
            awake_nxt = 1'b1;
            run_nxt   = ST_IDLE;
            phase_nxt = PH_NONE;
          end
          default: res_acc_nxt = 1'b0;
        endcase
      end
      // first mapping done: start or poll decision
      S_MAP1: begin
        if (map_stat.done) begin
          st_nxt = S_EMIT;
          if (op_r == OPC_START) begin
            oper_nxt   = item_oper_r;
            run_nxt    = ST_RUN;
            goal_nxt   = tgt_r;
            start_nxt  = now_r;
            motion_nxt = now_r;
            prev_nxt   = raw_r;
            phase_nxt  = PH_LOW;
            awake_nxt  = 1'b1;
            if (item_oper_r == OPER_CAL) begin
              ret_nxt = cur;
              drv_nxt = DRV_DN;
            end else if (item_oper_r == OPER_TEST) begin
              drv_nxt = DRV_BRAKE;
            end else if (abs18(18'(cur) - 18'(tgt_r)) <= 18'(tol_r)) begin
              run_nxt = ST_OK;
              drv_nxt = DRV_BRAKE;
            end else begin
              drv_nxt = (tgt_r > cur) ? DRV_UP : DRV_DN;
            end
          end else begin
            res_pos_nxt = cur;
            res_pv_nxt  = 1'b1;
            if (moved) begin
              prev_nxt   = raw_r;
              motion_nxt = now_r;
            end
            if (oper_r == OPER_TEST) begin
              if ((now_r - start_r) >= TIME_W'(settle_r)) begin
                drv_nxt   = DRV_BRAKE;
                awake_nxt = 1'b1;
                run_nxt   = ST_OK;
              end
            end else if (oper_r == OPER_CAL && phase_r == PH_LOW && ll_r) begin
              cap_lo_nxt   = raw_r;
              cap_lo_v_nxt = 1'b1;
              phase_nxt    = PH_HIGH;
              motion_nxt   = now_r;
              drv_nxt      = DRV_UP;
              awake_nxt    = 1'b1;
            end else if (oper_r == OPER_CAL && phase_r == PH_HIGH && lh_r) begin
              if (span_bad) begin
                drv_nxt   = DRV_BRAKE;
                awake_nxt = 1'b1;
                run_nxt   = ST_HWERR;
              end else begin
                // remap with the new high endpoint
                cap_hi_nxt     = raw_r;
                cap_hi_v_nxt   = 1'b1;
                phase_nxt      = PH_BACK;
                motion_nxt     = now_r;
                mcmd_nxt.raw   = raw_r;
                mcmd_nxt.lo    = lo_end;
                mcmd_nxt.hi    = raw_r;
                mcmd_nxt.tmin  = tmin_r;
                mcmd_nxt.tmax  = tmax_r;
                mcmd_nxt.start = 1'b1;
                st_nxt         = S_MAP2;
              end
            end else if (oper_r == OPER_CAL && phase_r == PH_BACK && at_ret) begin
              drv_nxt   = DRV_BRAKE;
              awake_nxt = 1'b1;
              run_nxt   = ST_OK;
            end else if (oper_r == OPER_CAL && phase_r == PH_BACK && lim_hit) begin
              drv_nxt   = DRV_BRAKE;
              awake_nxt = 1'b1;
              run_nxt   = ST_ACTJAM;
            end else if (oper_r != OPER_CAL && at_goal) begin
              drv_nxt   = DRV_BRAKE;
              awake_nxt = 1'b1;
              run_nxt   = ST_OK;
            end else if (oper_r != OPER_CAL && lim_hit) begin
              drv_nxt   = DRV_BRAKE;
              awake_nxt = 1'b1;
              run_nxt   = ST_ACTJAM;
            end else if (stall_hit) begin
              drv_nxt   = DRV_BRAKE;
              awake_nxt = 1'b1;
              run_nxt   = ST_MOTJAM;
            end
          end
        end
      end
      // second mapping after calibration: head back to the start tilt
      S_MAP2: begin
        if (map_stat.done) begin
          res_pos_nxt = cur;
          awake_nxt   = 1'b1;
          st_nxt      = S_EMIT;
          if (at_ret) begin
            drv_nxt = DRV_BRAKE;
            run_nxt = ST_OK;
          end else begin
            drv_nxt = (ret_r > cur) ? DRV_UP : DRV_DN;
          end
        end
      end
      // load the output register once it is free
      S_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          o_st_nxt  = res_hwant_r ? ST_HWERR : run_r;
          o_acc_nxt = res_acc_r;
          o_pv_nxt  = res_pv_r;
          o_pos_nxt = res_pos_r;
          o_dir_nxt = drv_r;
          o_aw_nxt  = awake_r;
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      tmin_r     <= 16'sd0;
      tmax_r     <= 16'sd100;
      tol_r      <= 10'd5;
      settle_r   <= 16'd1000;
      stall_to_r <= 16'd2000;
      min_span_r <= 12'd100;
      def_lo_r   <= 12'd0;
      def_hi_r   <= 12'd4095;
      run_r      <= ST_IDLE;
      oper_r     <= OPER_MOVE;
      phase_r    <= PH_NONE;
      goal_r     <= '0;
      ret_r      <= '0;
      start_r    <= '0;
      motion_r   <= '0;
      prev_r     <= '0;
      drv_r      <= DRV_BRAKE;
      awake_r    <= 1'b0;
      cap_lo_r   <= '0;
      cap_lo_v_r <= 1'b0;
      cap_hi_r   <= '0;
      cap_hi_v_r <= 1'b0;
      mcmd_r     <= '0;
      ov_r       <= 1'b0;
      o_aw_r     <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      run_r      <= run_nxt;
      oper_r     <= oper_nxt;
      phase_r    <= phase_nxt;
      goal_r     <= goal_nxt;
      ret_r      <= ret_nxt;
      start_r    <= start_nxt;
      motion_r   <= motion_nxt;
      prev_r     <= prev_nxt;
      drv_r      <= drv_nxt;
      awake_r    <= awake_nxt;
      cap_lo_r   <= cap_lo_nxt;
      cap_lo_v_r <= cap_lo_v_nxt;
      cap_hi_r   <= cap_hi_nxt;
      cap_hi_v_r <= cap_hi_v_nxt;
      mcmd_r     <= mcmd_nxt;
      ov_r       <= ov_nxt;
      o_aw_r     <= o_aw_nxt;
      // register writes; limit writes that break min < max are dropped
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TILT_MIN: if ($signed(cfg_wdata) < tmax_r) tmin_r <= $signed(cfg_wdata);
          REG_TILT_MAX: if (tmin_r < $signed(cfg_wdata)) tmax_r <= $signed(cfg_wdata);
          REG_TOL:      tol_r      <= cfg_wdata[TOL_W-1:0];
          REG_SETTLE:   settle_r   <= cfg_wdata;
          REG_STALL:    stall_to_r <= cfg_wdata;
          REG_MIN_SPAN: min_span_r <= cfg_wdata[SPAN_W-1:0];
          REG_DEF_LOW:  def_lo_r   <= cfg_wdata[ADC_W-1:0];
          REG_DEF_HIGH: def_hi_r   <= cfg_wdata[ADC_W-1:0];
          default: ;
        endcase
      end
    end
    // payload
    if (in_acc) begin
      op_r        <= in_opcode;
      item_oper_r <= in_operation;
      ant_r       <= in_antenna;
      tgt_r       <= in_target_tenths;
      raw_r       <= in_adc_sample;
      aok_r       <= in_adc_ok;
      flt_r       <= in_driver_fault;
      ll_r        <= in_limit_low;
      lh_r        <= in_limit_high;
      now_r       <= in_now_ms;
    end
    res_acc_r   <= res_acc_nxt;
    res_pv_r    <= res_pv_nxt;
    res_hwant_r <= res_hwant_nxt;
    res_pos_r   <= res_pos_nxt;
    o_st_r      <= o_st_nxt;
    o_acc_r     <= o_acc_nxt;
    o_pv_r      <= o_pv_nxt;
    o_pos_r     <= o_pos_nxt;
    o_dir_r     <= o_dir_nxt;
  end

  assign out_valid           = ov_r;
  assign out_status          = o_st_r;
  assign out_accepted        = o_acc_r;
  assign out_tilt_tenths     = o_pos_r;
  assign out_position_valid  = o_pv_r;
  assign out_drive_direction = o_dir_r;
  assign out_driver_awake    = o_aw_r;
  assign map_cmd             = mcmd_r;

endmodule
`default_nettype wire

// ===== src/tilt_actuator_position_controller.sv =====
// Mapping: start and poll beats that map a sample wait on the tilt divider, which
//   takes one bit per cycle (30 steps plus multiply and fix-up).
//   A calibration poll that captures the high endpoint maps twice.
//   Stop, rejected and unmapped beats skip the mapping datapath.
// Throughput: one beat at a time; the next is taken while a result waits.
// Reset: synchronous active-low; configuration returns to its defaults.
// ----------------------------------------------------------------------------
// tilt_actuator_position_controller: top level
// DC tilt actuator move, calibration and self-test control from ADC samples.
// ----------------------------------------------------------------------------
`default_nettype none
module tilt_actuator_position_controller (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire [1:0]          in_opcode,
  input  wire [1:0]          in_operation,
  input  wire [7:0]          in_antenna,
  input  wire signed [15:0]  in_target_tenths,
  input  wire [11:0]         in_adc_sample,
  input  wire                in_adc_ok,
  input  wire                in_driver_fault,
  input  wire                in_limit_low,
  input  wire                in_limit_high,
  input  wire [31:0]         in_now_ms,
  input  wire                cfg_we,
  input  wire [3:0]          cfg_index,
  input  wire [15:0]         cfg_wdata,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [2:0]         out_status,
  output logic               out_accepted,
  output logic signed [15:0] out_tilt_tenths,
  output logic               out_position_valid,
  output logic signed [1:0]  out_drive_direction,
  output logic               out_driver_awake
);
  import tapc_pkg::*;

  map_cmd_t  map_cmd;
  map_stat_t map_stat;

  tapc_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_operation        (in_operation),
    .in_antenna          (in_antenna),
    .in_target_tenths    (in_target_tenths),
    .in_adc_sample       (in_adc_sample),
    .in_adc_ok           (in_adc_ok),
    .in_driver_fault     (in_driver_fault),
    .in_limit_low        (in_limit_low),
    .in_limit_high       (in_limit_high),
    .in_now_ms           (in_now_ms),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_accepted        (out_accepted),
    .out_tilt_tenths     (out_tilt_tenths),
    .out_position_valid  (out_position_valid),
    .out_drive_direction (out_drive_direction),
    .out_driver_awake    (out_driver_awake),
    .map_cmd             (map_cmd),
    .map_stat            (map_stat)
  );

  tapc_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (map_cmd),
    .stat  (map_stat)
  );

endmodule
`default_nettype wire

// ===== src/tapc_checker.sv =====
// ----------------------------------------------------------------------------
// tapc_checker: port-level checks for the tilt actuator controller
// Watches the result channel and bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module tapc_checker (
  input wire              clk,
  input wire              rst_n,
  input wire              out_valid,
  input wire              out_stall,
  input wire [2:0]        out_status,
  input wire              out_accepted,
  input wire signed [15:0] out_tilt_tenths,
  input wire              out_position_valid,
  input wire signed [1:0] out_drive_direction,
  input wire              out_driver_awake
);
  import tapc_pkg::*;

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_tilt_tenths))
    else $error("stalled result beat changed");

  // unmapped beats carry a zero position
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_position_valid |-> out_tilt_tenths == 16'sd0)
    else $error("position without a mapped sample");

  // a mapped poll is always accepted and never idle
  a_pos_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_position_valid |-> out_accepted && out_status != ST_IDLE)
    else $error("mapped beat with bad accept or status");

  // driver wake is sticky
  a_awake: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_driver_awake) |-> out_driver_awake)
    else $error("driver awake dropped");

  // direction code is one of up, down, brake
  a_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_direction != 2'sb10)
    else $error("invalid drive direction");

endmodule

bind tilt_actuator_position_controller tapc_checker u_tapc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_status          (out_status),
  .out_accepted        (out_accepted),
  .out_tilt_tenths     (out_tilt_tenths),
  .out_position_valid  (out_position_valid),
  .out_drive_direction (out_drive_direction),
  .out_driver_awake    (out_driver_awake)
);
`default_nettype wire
